>>> hw/rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared definitions for the circular deque
// Field widths, operation codes, state machine and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

    localparam int MAX_SLOTS_DEF = 1024;
    localparam int ELEM_BITS_DEF = 32;

    localparam int FUNC_W  = 3;
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 11;

    localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_REAR  = 3'd1,
        FN_DEL_FRONT = 3'd2,
        FN_DEL_REAR  = 3'd3,
        FN_QUERY     = 3'd4
    } t_func;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } t_state;

    typedef struct packed {
        logic ok;
        logic empty;
        logic full;
    } t_status;

endpackage

`default_nettype wire

>>> hw/rtl/cdq_if.sv
// ----------------------------------------------------------------------------
// cdq_in_if / cdq_out_if: valid-ready channels of the circular deque
// The input channel carries an operation and a value, the output one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_in_if;
    logic                               valid;
    logic                               ready;
    logic [cdq_pkg::FUNC_W-1:0]         func;
    logic signed [cdq_pkg::VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface cdq_out_if;
    logic                               valid;
    logic                               ready;
    logic                               ok;
    logic signed [cdq_pkg::VALUE_W-1:0] front_value;
    logic signed [cdq_pkg::VALUE_W-1:0] rear_value;
    logic                               is_empty;
    logic                               is_full;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue in a ring memory
// Operation sequencing, ring memory read-back and the result register.
// ----------------------------------------------------------------------------
// Each input word is accepted in ST_IDLE, where the pointers move and the ring
// memory is written and read at the new head and tail; in ST_RESP the
// registered read data becomes the result word once the output register is
// free. The registered read of the ring memory is why ST_RESP follows. The
// next word is accepted while the previous result still waits in the output
// register. Writing the capacity register empties the deque; the memory needs
// no clearing pass, since only slots written by inserts reach a result word.
`default_nettype none

module circular_deque #(
    parameter int MAX_SLOTS = cdq_pkg::MAX_SLOTS_DEF,
    parameter int ELEM_BITS = cdq_pkg::ELEM_BITS_DEF,
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [cdq_pkg::CFG_W-1:0] i_cfg_data,
    cdq_in_if.sink                         i_in,
    cdq_out_if.source                      o_out
);

    cdq_pkg::t_state  r_state, n_state;
    cdq_pkg::t_status r_stat;
    cdq_pkg::t_status stat;

    logic                 accept;
    logic                 load;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        head;
    logic [AW-1:0]        tail;
    logic [ELEM_BITS-1:0] wr_data;
    logic [ELEM_BITS-1:0] rd_front;
    logic [ELEM_BITS-1:0] rd_rear;

    logic                               r_out_valid;
    logic                               r_ok;
    logic                               r_empty;
    logic                               r_full;
    logic signed [cdq_pkg::VALUE_W-1:0] r_front;
    logic signed [cdq_pkg::VALUE_W-1:0] r_rear;

    assign accept  = i_in.valid && i_in.ready;
    assign wr_data = ELEM_BITS'($unsigned(i_in.value));

    cdq_ptr #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ptr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_step     (accept),
        .i_func     (i_in.func),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_head     (head),
        .o_tail     (tail),
        .o_status   (stat)
    );

    cdq_ring_mem #(
        .MAX_SLOTS (MAX_SLOTS),
        .ELEM_BITS (ELEM_BITS)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en && accept),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (accept),
        .i_rd_addr_a (head),
        .i_rd_addr_b (tail),
        .o_rd_data_a (rd_front),
        .o_rd_data_b (rd_rear)
    );

    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        load       = 1'b0;
        case (r_state)
            cdq_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_state = cdq_pkg::ST_RESP;
                end
            end
            cdq_pkg::ST_RESP: begin
                load = !r_out_valid || o_out.ready;
                if (load) begin
                    n_state = cdq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stat <= stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // An empty deque reports all ones for both ends.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ok    <= r_stat.ok;
            r_empty <= r_stat.empty;
            r_full  <= r_stat.full;
            r_front <= r_stat.empty ? '1 : cdq_pkg::VALUE_W'(rd_front);
            r_rear  <= r_stat.empty ? '1 : cdq_pkg::VALUE_W'(rd_rear);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.ok          = r_ok;
    assign o_out.front_value = r_front;
    assign o_out.rear_value  = r_rear;
    assign o_out.is_empty    = r_empty;
    assign o_out.is_full     = r_full;

    a_accept_to_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == cdq_pkg::ST_RESP))
        else $error("accepted word did not enter the response cycle");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_out.valid)
        else $error("result register loaded without raising valid");

    a_empty_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_empty) |->
            ((o_out.front_value == '1) && (o_out.rear_value == '1) && !o_out.is_full))
        else $error("empty deque result without sentinel values");

endmodule

`default_nettype wire

>>> hw/rtl/cdq_ring_mem.sv
// ----------------------------------------------------------------------------
// cdq_ring_mem: ring store of the deque
// One write port and two registered read ports, with write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ring_mem #(
    parameter int MAX_SLOTS = cdq_pkg::MAX_SLOTS_DEF,
    parameter int ELEM_BITS = cdq_pkg::ELEM_BITS_DEF,
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [AW-1:0]        i_wr_addr,
    input  wire logic [ELEM_BITS-1:0] i_wr_data,
    input  wire logic                 i_rd_en,
    input  wire logic [AW-1:0]        i_rd_addr_a,
    input  wire logic [AW-1:0]        i_rd_addr_b,
    output logic      [ELEM_BITS-1:0] o_rd_data_a,
    output logic      [ELEM_BITS-1:0] o_rd_data_b
);

    logic [ELEM_BITS-1:0] r_mem [MAX_SLOTS];
    logic [ELEM_BITS-1:0] r_q_a;
    logic [ELEM_BITS-1:0] r_q_b;
    logic [ELEM_BITS-1:0] r_wdata;
    logic                 r_fwd_a;
    logic                 r_fwd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A read issued in the same cycle as a write to that slot sees the new word.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q_a   <= r_mem[i_rd_addr_a];
            r_q_b   <= r_mem[i_rd_addr_b];
            r_wdata <= i_wr_data;
            r_fwd_a <= i_wr_en && (i_wr_addr == i_rd_addr_a);
            r_fwd_b <= i_wr_en && (i_wr_addr == i_rd_addr_b);
        end
    end

    assign o_rd_data_a = r_fwd_a ? r_wdata : r_q_a;
    assign o_rd_data_b = r_fwd_b ? r_wdata : r_q_b;

endmodule

`default_nettype wire

>>> hw/rtl/cdq_ptr.sv
// ----------------------------------------------------------------------------
// cdq_ptr: head, tail and count bookkeeping of the deque
// Decodes one operation, moves the pointers with wrap at the capacity in use.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ptr #(
    parameter int MAX_SLOTS = cdq_pkg::MAX_SLOTS_DEF,
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int CW = $clog2(MAX_SLOTS + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [cdq_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                        i_step,
    input  wire logic [cdq_pkg::FUNC_W-1:0]  i_func,
    output logic                             o_wr_en,
    output logic      [AW-1:0]               o_wr_addr,
    output logic      [AW-1:0]               o_head,
    output logic      [AW-1:0]               o_tail,
    output cdq_pkg::t_status                 o_status
);

    function automatic logic [CW-1:0] eff_cap(input logic [cdq_pkg::CFG_W-1:0] c);
        logic [CW-1:0] r;
        if (c == '0) begin
            r = CW'(1);
        end else if (32'(c) > MAX_SLOTS) begin
            r = CW'(MAX_SLOTS);
        end else begin
            r = CW'(c);
        end
        return r;
    endfunction

    logic [CW-1:0] r_cap;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    logic          bad;
    logic [AW-1:0] cur_head, cur_tail;
    logic [CW-1:0] cur_count;
    logic [CW-1:0] head_inc, tail_inc;
    logic [AW-1:0] head_up, head_dn, tail_up, tail_dn;
    logic          ok;

    always_comb begin
        // Pointers outside the ring fall back to an empty deque.
        bad       = (CW'(r_head) >= r_cap) || (CW'(r_tail) >= r_cap) || (r_count > r_cap);
        cur_head  = bad ? '0 : r_head;
        cur_tail  = bad ? '0 : r_tail;
        cur_count = bad ? '0 : r_count;

        head_inc = CW'(cur_head) + CW'(1);
        tail_inc = CW'(cur_tail) + CW'(1);
        head_up  = (head_inc >= r_cap) ? '0 : AW'(head_inc);
        tail_up  = (tail_inc >= r_cap) ? '0 : AW'(tail_inc);
        head_dn  = (cur_head == '0) ? AW'(r_cap - CW'(1)) : cur_head - AW'(1);
        tail_dn  = (cur_tail == '0) ? AW'(r_cap - CW'(1)) : cur_tail - AW'(1);

        ok        = 1'b1;
        n_head    = cur_head;
        n_tail    = cur_tail;
        n_count   = cur_count;
        o_wr_en   = 1'b0;
        o_wr_addr = '0;

        case (cdq_pkg::t_func'(i_func))
            cdq_pkg::FN_INS_FRONT, cdq_pkg::FN_INS_REAR: begin
                if (cur_count >= r_cap) begin
                    ok = 1'b0;
                end else if (cur_count == '0) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = CW'(1);
                    o_wr_en = 1'b1;
                end else if (cdq_pkg::t_func'(i_func) == cdq_pkg::FN_INS_FRONT) begin
                    n_head    = head_dn;
                    n_count   = cur_count + CW'(1);
                    o_wr_en   = 1'b1;
                    o_wr_addr = head_dn;
                end else begin
                    n_tail    = tail_up;
                    n_count   = cur_count + CW'(1);
                    o_wr_en   = 1'b1;
                    o_wr_addr = tail_up;
                end
            end
            cdq_pkg::FN_DEL_FRONT, cdq_pkg::FN_DEL_REAR: begin
                if (cur_count == '0) begin
                    ok = 1'b0;
                end else if (cur_count == CW'(1)) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end else if (cdq_pkg::t_func'(i_func) == cdq_pkg::FN_DEL_FRONT) begin
                    n_head  = head_up;
                    n_count = cur_count - CW'(1);
                end else begin
                    n_tail  = tail_dn;
                    n_count = cur_count - CW'(1);
                end
            end
            default: begin
            end
        endcase

        o_head         = n_head;
        o_tail         = n_tail;
        o_status.ok    = ok;
        o_status.empty = (n_count == '0);
        o_status.full  = (n_count == r_cap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= eff_cap(cdq_pkg::CAP_RESET);
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_cap   <= eff_cap(i_cfg_data);
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("element count exceeds capacity");

    a_head_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_head) < r_cap) && (CW'(r_tail) < r_cap))
        else $error("pointer outside the ring");

    a_cfg_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_count == '0))
        else $error("capacity write did not empty the deque");

endmodule

`default_nettype wire

>>> verif/tb_circular_deque.sv
// ----------------------------------------------------------------------------
// tb_circular_deque: self-checking testbench for the circular deque
// A scoreboard class predicts every result word from the operations accepted
// at the input and checks the output stream in order. Directed operations
// come first, then random phases over several capacities with random idle
// cycles on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_circular_deque;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYC   = 9;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_PHASES    = 8;

    // Codes 5 to 7 are unused and behave like a query.
    localparam logic [cdq_pkg::FUNC_W-1:0] FN_SPARE_LO = 3'd5;
    localparam logic [cdq_pkg::FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    localparam logic [cdq_pkg::VALUE_W-1:0] EMPTY_MARK = '1;

    typedef struct packed {
        logic                        ok;
        logic [cdq_pkg::VALUE_W-1:0] front_value;
        logic [cdq_pkg::VALUE_W-1:0] rear_value;
        logic                        is_empty;
        logic                        is_full;
    } t_deque_result;

    class deque_scoreboard;
        logic [cdq_pkg::VALUE_W-1:0] slot_q [cdq_pkg::MAX_SLOTS_DEF];
        int unsigned                 head_q;
        int unsigned                 tail_q;
        int unsigned                 count_q;
        logic [cdq_pkg::CFG_W-1:0]   cap_reg;
        t_deque_result               expected_q [$];
        int                          mismatches;
        int                          words_checked;
        int                          rejected;
        int                          full_seen;

        function new();
            cap_reg       = cdq_pkg::CAP_RESET;
            head_q        = 0;
            tail_q        = 0;
            count_q       = 0;
            mismatches    = 0;
            words_checked = 0;
            rejected      = 0;
            full_seen     = 0;
        endfunction

        function int unsigned usable_slots();
            int unsigned c;
            c = cap_reg;
            if (c == 0) c = 1;
            if (c > cdq_pkg::MAX_SLOTS_DEF) c = cdq_pkg::MAX_SLOTS_DEF;
            return c;
        endfunction

        // A capacity write also empties the deque.
        function void write_capacity(logic [cdq_pkg::CFG_W-1:0] c);
            cap_reg = c;
            head_q  = 0;
            tail_q  = 0;
            count_q = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_word(logic [cdq_pkg::FUNC_W-1:0] f,
                                logic [cdq_pkg::VALUE_W-1:0] v);
            int unsigned   cap;
            t_deque_result r;
            cap  = usable_slots();
            r.ok = 1'b1;
            case (f)
                cdq_pkg::FN_INS_FRONT, cdq_pkg::FN_INS_REAR: begin
                    if (count_q >= cap) begin
                        r.ok = 1'b0;
                    end else if (count_q == 0) begin
                        head_q    = 0;
                        tail_q    = 0;
                        slot_q[0] = v;
                        count_q   = 1;
                    end else if (f == cdq_pkg::FN_INS_FRONT) begin
                        head_q         = (head_q == 0) ? cap - 1 : head_q - 1;
                        slot_q[head_q] = v;
                        count_q++;
                    end else begin
                        tail_q         = (tail_q + 1 >= cap) ? 0 : tail_q + 1;
                        slot_q[tail_q] = v;
                        count_q++;
                    end
                end
                cdq_pkg::FN_DEL_FRONT, cdq_pkg::FN_DEL_REAR: begin
                    if (count_q == 0) begin
                        r.ok = 1'b0;
                    end else begin
                        count_q--;
                        if (count_q == 0) begin
                            head_q = 0;
                            tail_q = 0;
                        end else if (f == cdq_pkg::FN_DEL_FRONT) begin
                            head_q = (head_q + 1 >= cap) ? 0 : head_q + 1;
                        end else begin
                            tail_q = (tail_q == 0) ? cap - 1 : tail_q - 1;
                        end
                    end
                end
                default: ;
            endcase
            r.front_value = (count_q == 0) ? EMPTY_MARK : slot_q[head_q];
            r.rear_value  = (count_q == 0) ? EMPTY_MARK : slot_q[tail_q];
            r.is_empty    = (count_q == 0);
            r.is_full     = (count_q == cap);
            if (!r.ok) rejected++;
            if (r.is_full) full_seen++;
            expected_q.push_back(r);
        endfunction

        task report(string field, logic [cdq_pkg::VALUE_W-1:0] got,
                    logic [cdq_pkg::VALUE_W-1:0] want);
            $display("MISMATCH result %0d: %s got %h want %h", words_checked, field, got, want);
            mismatches++;
        endtask

        task check_word(t_deque_result got);
            t_deque_result want;
            if (expected_q.size() == 0) begin
                report("unexpected word", got.front_value, '0);
                words_checked++;
                return;
            end
            want = expected_q.pop_front();
            if (got.ok !== want.ok) report("ok", got.ok, want.ok);
            if (got.front_value !== want.front_value)
                report("front_value", got.front_value, want.front_value);
            if (got.rear_value !== want.rear_value)
                report("rear_value", got.rear_value, want.rear_value);
            if (got.is_empty !== want.is_empty) report("is_empty", got.is_empty, want.is_empty);
            if (got.is_full !== want.is_full) report("is_full", got.is_full, want.is_full);
            words_checked++;
        endtask
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [cdq_pkg::CFG_W-1:0] i_cfg_data;

    cdq_in_if  in_ch ();
    cdq_out_if out_ch ();

    circular_deque DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    deque_scoreboard sb;
    logic            tx_calm;
    logic            rx_calm;
    int              cycle_count;
    int              settings_used;

    int          phase_items [N_PHASES] = '{80, 120, 120, 1150, 120, 60, 80, 80};
    int          phase_ins   [N_PHASES] = '{45, 45, 50, 95, 40, 50, 40, 35};
    int          phase_del   [N_PHASES] = '{40, 45, 40, 3, 40, 40, 40, 55};
    logic [10:0] phase_cap   [N_PHASES] = '{11'd0, 11'd2, 11'd3, 11'd2047,
                                            11'd7, 11'd1024, 11'd1, 11'd5};

    initial begin
        i_clk = 1'b0;
        sb    = new();
    end

    always begin
        #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Called at the edge where the previous word was taken, so valid only
    // drops when a gap is drawn.
    task automatic send_word(input logic [cdq_pkg::FUNC_W-1:0] f,
                             input logic [cdq_pkg::VALUE_W-1:0] v);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func  <= f;
        in_ch.value <= v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_word(f, v);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic set_capacity(input logic [cdq_pkg::CFG_W-1:0] c);
        wait_drained();
        repeat (3) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_capacity(c);
        settings_used++;
    endtask

    function automatic logic [cdq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [cdq_pkg::FUNC_W-1:0] pick_op(input int ins_pct,
                                                           input int del_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            return $urandom_range(0, 1) ? cdq_pkg::FN_INS_FRONT : cdq_pkg::FN_INS_REAR;
        if (r < ins_pct + del_pct)
            return $urandom_range(0, 1) ? cdq_pkg::FN_DEL_FRONT : cdq_pkg::FN_DEL_REAR;
        return cdq_pkg::FUNC_W'($urandom_range(cdq_pkg::FN_QUERY, FN_SPARE_HI));
    endfunction

    task automatic run_directed();
        // Empty deque at the reset capacity: queries and failing deletes.
        send_word(cdq_pkg::FN_QUERY, 32'h1234_5678);
        send_word(cdq_pkg::FN_DEL_FRONT, '0);
        send_word(cdq_pkg::FN_DEL_REAR, '1);
        // First insert lands in slot 0, the next front insert wraps the head.
        send_word(cdq_pkg::FN_INS_REAR, 32'h7FFF_FFFF);
        send_word(cdq_pkg::FN_INS_FRONT, 32'h8000_0000);
        send_word(cdq_pkg::FN_INS_REAR, '1);
        send_word(cdq_pkg::FN_INS_FRONT, '0);
        send_word(cdq_pkg::FN_INS_REAR, 32'h5555_5555);
        send_word(cdq_pkg::FN_INS_FRONT, 32'hAAAA_AAAA);
        send_word(FN_SPARE_LO, 32'hDEAD_BEEF);
        send_word(FN_SPARE_LO + 3'd1, '0);
        send_word(FN_SPARE_HI, '1);
        send_word(cdq_pkg::FN_DEL_FRONT, '0);
        send_word(cdq_pkg::FN_DEL_REAR, '0);
        send_word(cdq_pkg::FN_DEL_FRONT, '0);
        send_word(cdq_pkg::FN_DEL_FRONT, '0);
        send_word(cdq_pkg::FN_DEL_REAR, '0);
        send_word(cdq_pkg::FN_DEL_REAR, '0);
        send_word(cdq_pkg::FN_DEL_FRONT, '0);
        // A single slot: the second insert finds the deque full.
        set_capacity(11'd1);
        send_word(cdq_pkg::FN_INS_FRONT, 32'h0F0F_0F0F);
        send_word(cdq_pkg::FN_INS_REAR, 32'hF0F0_F0F0);
        send_word(cdq_pkg::FN_QUERY, '0);
        send_word(cdq_pkg::FN_DEL_REAR, '0);
        send_word(cdq_pkg::FN_DEL_FRONT, '0);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.func    = '0;
        in_ch.value   = '0;
        tx_calm       = 1'b0;
        settings_used = 1;
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int p = 0; p < N_PHASES; p++) begin
            set_capacity(phase_cap[p]);
            tx_calm <= ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_items[p]; n++) begin
                send_word(pick_op(phase_ins[p], phase_del[p]), pick_value());
                // Now and then hold off until the deque has answered everything.
                if ($urandom_range(0, 63) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("Checked %0d result words over %0d capacity settings (register 0 to 2047).",
                 sb.words_checked, settings_used);
        $display("%0d operations were rejected and %0d results showed a full deque.",
                 sb.rejected, sb.full_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Result side: a random stall before each word, none in calm stretches.
    initial begin
        int            stall;
        t_deque_result got;
        out_ch.ready = 1'b0;
        rx_calm      = 1'b0;
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            got.ok          = out_ch.ok;
            got.front_value = out_ch.front_value;
            got.rear_value  = out_ch.rear_value;
            got.is_empty    = out_ch.is_empty;
            got.is_full     = out_ch.is_full;
            sb.check_word(got);
            if ($urandom_range(0, 199) == 0) rx_calm <= ~rx_calm;
        end
    end

endmodule

`default_nettype wire
